>>> design/arithmetic_encoder_32bit_assert.svh
// Assertion macros used by the arithmetic encoder core (ae32_back).
`ifndef ARITHMETIC_ENCODER_32BIT_ASSERT_SVH
`define ARITHMETIC_ENCODER_32BIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define AE32_CHECK(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define AE32_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/ae32_pkg.sv
// Types, constants and helpers for the arithmetic encoder.
package ae32_pkg;

  localparam int PREC     = 32;
  localparam int FREQ     = 16;
  localparam int CNT_W    = 48;
  localparam int NUM_W    = PREC + 1 + FREQ;
  localparam int MAX_EMIT = 32;

  typedef enum logic [1:0] {
    JOB_ENC,
    JOB_FIN,
    JOB_BAD
  } job_kind_t;

  typedef struct packed {
    logic            cmd;
    logic [FREQ-1:0] cum_low;
    logic [FREQ-1:0] cum_high;
    logic [FREQ-1:0] total_count;
  } enc_in_t;

  typedef struct packed {
    logic             has_bit;
    logic             bit_value;
    logic [31:0]      follow_count;
    logic [CNT_W-1:0] bits_so_far;
    logic             error;
    logic             last;
  } enc_out_t;

  typedef struct packed {
    job_kind_t       kind;
    logic [FREQ-1:0] cl;
    logic [FREQ-1:0] ch;
    logic [FREQ-1:0] tot;
  } job_t;

  function automatic logic [CNT_W-1:0] sat_cnt(input logic [CNT_W:0] s);
    return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
  endfunction

endpackage

>>> design/ae32_front.sv
// Front end: checks and classifies requests, holds them in a two-entry queue.
module ae32_front
  import ae32_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  output logic    full,
  input  enc_in_t item,
  output job_t    job,
  output logic    job_valid,
  input  logic    job_take
);

  job_t       q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  job_t       cls;
  logic       do_wr;
  logic       do_rd;

  always_comb begin
    cls.cl  = item.cum_low;
    cls.ch  = item.cum_high;
    cls.tot = item.total_count;
    if (item.cmd) begin
      cls.kind = JOB_FIN;
    end else if (item.total_count == '0 || item.cum_low >= item.cum_high ||
                 item.cum_high > item.total_count) begin
      cls.kind = JOB_BAD;
    end else begin
      cls.kind = JOB_ENC;
    end
  end

  assign full      = (count == 2'd2);
  assign job_valid = (count != 2'd0);
  assign job       = q[rd_ptr];
  assign do_wr     = push && !full;
  assign do_rd     = job_take && job_valid;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      q[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (do_wr) wr_ptr <= ~wr_ptr;
      if (do_rd) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, do_wr} - {1'b0, do_rd};
    end
  end

endmodule

>>> design/ae32_rq.sv
// Result queue between the coder core and the output port.
module ae32_rq
  import ae32_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     wr,
  input  enc_out_t wdata,
  output logic     wfull,
  input  logic     rd,
  output enc_out_t rdata,
  output logic     rempty
);

  enc_out_t   mem [4];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] count;
  logic       do_wr;
  logic       do_rd;

  assign wfull  = (count == 3'd4);
  assign rempty = (count == 3'd0);
  assign rdata  = mem[rd_ptr];
  assign do_wr  = wr && !wfull;
  assign do_rd  = rd && !rempty;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) wr_ptr <= wr_ptr + 2'd1;
      if (do_rd) rd_ptr <= rd_ptr + 2'd1;
      count <= count + {2'b0, do_wr} - {2'b0, do_rd};
    end
  end

endmodule

>>> design/ae32_back.sv
// Coder core: interval narrowing, shared-step division and renormalisation.
module ae32_back
  import ae32_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  job_t     job,
  input  logic     job_valid,
  output logic     job_take,
  output logic     oq_push,
  output enc_out_t oq_data,
  input  logic     oq_full
);

`include "arithmetic_encoder_32bit_assert.svh"

  localparam int DCW = $clog2(NUM_W);
  localparam int ECW = $clog2(MAX_EMIT + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL_LO,
    S_MUL_HI,
    S_DIV,
    S_UPD,
    S_RENORM,
    S_FLUSH
  } state_t;

  state_t           state;
  logic [PREC-1:0]  interval_low;
  logic [PREC-1:0]  interval_high;
  logic [31:0]      pending_count;
  logic [CNT_W-1:0] emitted_count;
  logic [FREQ-1:0]  cl;
  logic [FREQ-1:0]  ch;
  logic [FREQ-1:0]  tot;
  logic [NUM_W-1:0] num_lo;
  logic [NUM_W-1:0] num_hi;
  logic [FREQ-1:0]  rem_lo;
  logic [FREQ-1:0]  rem_hi;
  logic [DCW-1:0]   div_cnt;
  logic [ECW-1:0]   emit_cnt;
  enc_out_t         buf_res;
  logic             have_buf;

  logic [PREC:0]    rng;
  logic [FREQ-1:0]  mul_op;
  logic [NUM_W-1:0] prod;
  logic [FREQ:0]    r2_lo;
  logic [FREQ:0]    r2_hi;
  logic             ge_lo;
  logic             ge_hi;
  logic [PREC:0]    q_lo;
  logic [PREC:0]    q_hi;
  logic [31:0]      pend_inc;
  logic [CNT_W-1:0] so_far;
  logic [CNT_W-1:0] em_emit;
  logic [CNT_W-1:0] em_fin;
  logic             c_zero;
  logic             c_one;
  logic             c_mid;
  logic             emit;
  logic             fin_go;

  assign rng    = {1'b0, interval_high} - {1'b0, interval_low} + 1'b1;
  assign mul_op = (state == S_MUL_LO) ? cl : ch;
  assign prod   = NUM_W'(rng) * NUM_W'(mul_op);

  // one restoring step per lane
  assign r2_lo = {rem_lo, num_lo[NUM_W-1]};
  assign r2_hi = {rem_hi, num_hi[NUM_W-1]};
  assign ge_lo = (r2_lo >= {1'b0, tot});
  assign ge_hi = (r2_hi >= {1'b0, tot});
  assign q_lo  = num_lo[PREC:0];
  assign q_hi  = num_hi[PREC:0];

  assign pend_inc = (pending_count == '1) ? pending_count : pending_count + 32'd1;
  assign so_far   = sat_cnt({1'b0, emitted_count} + (CNT_W+1)'(pending_count));
  assign em_emit  = sat_cnt({1'b0, emitted_count} + (CNT_W+1)'(pending_count)
                            + (CNT_W+1)'(1));
  assign em_fin   = sat_cnt({1'b0, emitted_count} + (CNT_W+1)'(pend_inc)
                            + (CNT_W+1)'(1));

  assign c_zero = !interval_high[PREC-1];
  assign c_one  = interval_low[PREC-1];
  assign c_mid  = interval_low[PREC-2] && !interval_high[PREC-2];
  assign emit   = c_zero || c_one;

  assign job_take = (state == S_IDLE) && job_valid && !oq_full;
  assign fin_go   = job_take && (job.kind == JOB_FIN);

  always_comb begin
    oq_push = 1'b0;
    oq_data = '0;
    case (state)
      S_IDLE: begin
        if (job_take) begin
          case (job.kind)
            JOB_FIN: begin
              oq_push              = 1'b1;
              oq_data.has_bit      = 1'b1;
              oq_data.bit_value    = (interval_low[PREC-1:PREC-2] != 2'b00);
              oq_data.follow_count = pend_inc;
              oq_data.bits_so_far  = em_fin;
              oq_data.last         = 1'b1;
            end
            JOB_BAD: begin
              oq_push             = 1'b1;
              oq_data.bits_so_far = so_far;
              oq_data.error       = 1'b1;
              oq_data.last        = 1'b1;
            end
            default: ;
          endcase
        end
      end
      S_UPD: begin
        if (q_hi <= q_lo && !oq_full) begin
          oq_push             = 1'b1;
          oq_data.bits_so_far = so_far;
          oq_data.error       = 1'b1;
          oq_data.last        = 1'b1;
        end
      end
      S_RENORM: begin
        if (emit && have_buf && !oq_full) begin
          oq_push = 1'b1;
          oq_data = buf_res;
        end
      end
      S_FLUSH: begin
        if (!oq_full) begin
          oq_push = 1'b1;
          if (have_buf) oq_data = buf_res;
          oq_data.bits_so_far = so_far;
          oq_data.last        = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      interval_low  <= '0;
      interval_high <= '1;
      pending_count <= '0;
      emitted_count <= '0;
      have_buf      <= 1'b0;
      emit_cnt      <= '0;
      div_cnt       <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (job_take) begin
            case (job.kind)
              JOB_FIN: begin
                interval_low  <= '0;
                interval_high <= '1;
                pending_count <= '0;
                emitted_count <= '0;
              end
              JOB_ENC: begin
                cl    <= job.cl;
                ch    <= job.ch;
                tot   <= job.tot;
                state <= S_MUL_LO;
              end
              default: ;
            endcase
          end
        end
        S_MUL_LO: begin
          num_lo <= prod;
          state  <= S_MUL_HI;
        end
        S_MUL_HI: begin
          num_hi  <= prod;
          rem_lo  <= '0;
          rem_hi  <= '0;
          div_cnt <= '0;
          state   <= S_DIV;
        end
        S_DIV: begin
          rem_lo  <= ge_lo ? FREQ'(r2_lo - {1'b0, tot}) : r2_lo[FREQ-1:0];
          rem_hi  <= ge_hi ? FREQ'(r2_hi - {1'b0, tot}) : r2_hi[FREQ-1:0];
          num_lo  <= {num_lo[NUM_W-2:0], ge_lo};
          num_hi  <= {num_hi[NUM_W-2:0], ge_hi};
          div_cnt <= div_cnt + 1'b1;
          if (div_cnt == DCW'(NUM_W - 1)) state <= S_UPD;
        end
        S_UPD: begin
          if (q_hi <= q_lo) begin
            if (!oq_full) state <= S_IDLE;
          end else begin
            interval_high <= interval_low + q_hi[PREC-1:0] - 1'b1;
            interval_low  <= interval_low + q_lo[PREC-1:0];
            have_buf      <= 1'b0;
            emit_cnt      <= '0;
            state         <= S_RENORM;
          end
        end
        S_RENORM: begin
          if (emit) begin
            if (!(have_buf && oq_full)) begin
              buf_res.has_bit      <= 1'b1;
              buf_res.bit_value    <= c_one;
              buf_res.follow_count <= pending_count;
              buf_res.bits_so_far  <= em_emit;
              buf_res.error        <= 1'b0;
              buf_res.last         <= 1'b0;
              have_buf             <= 1'b1;
              emitted_count        <= em_emit;
              pending_count        <= '0;
              interval_low         <= {interval_low[PREC-2:0], 1'b0};
              interval_high        <= {interval_high[PREC-2:0], 1'b1};
              emit_cnt             <= emit_cnt + 1'b1;
              if (emit_cnt == ECW'(MAX_EMIT - 1)) state <= S_FLUSH;
            end
          end else if (c_mid) begin
            // middle-half straddle: defer the bit
            pending_count <= pend_inc;
            interval_low  <= {1'b0, interval_low[PREC-3:0], 1'b0};
            interval_high <= {1'b1, interval_high[PREC-3:0], 1'b1};
          end else begin
            state <= S_FLUSH;
          end
        end
        S_FLUSH: begin
          if (!oq_full) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `AE32_CHECK(a_push_room, oq_push, !oq_full, "result written into a full queue")
  `AE32_CHECK(a_interval_order, 1'b1, interval_low <= interval_high, "interval inverted")
  `AE32_CHECK_NEXT(a_finish_clears, fin_go,
                   interval_low == '0 && pending_count == '0 && emitted_count == '0,
                   "finish did not clear coder state")
  `AE32_CHECK(a_emit_bound, state == S_RENORM, emit_cnt < ECW'(MAX_EMIT),
              "too many bits emitted for one symbol")

endmodule

>>> design/arithmetic_encoder_32bit.sv
// Binary arithmetic encoder, 32-bit interval with pending-bit counter.
// Finish and front-flagged bad-count requests are answered in the cycle they are taken;
//   an encode runs take, 2 multiply and 49 divide steps, update, renorm shifts up to the
//   exit check or 32 emitted bits, and flush, plus any stall on a full result queue.
// Throughput: one request in the core at a time; it takes the next once an encode ends.
// Reset: synchronous rst clears queues and returns the interval to full range.
module arithmetic_encoder_32bit
  import ae32_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  output logic     full,
  input  enc_in_t  item,
  output logic     empty,
  input  logic     pop,
  output enc_out_t result
);

  job_t     job;
  logic     job_valid;
  logic     job_take;
  logic     oq_push;
  enc_out_t oq_data;
  logic     oq_full;

  ae32_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item      (item),
    .job       (job),
    .job_valid (job_valid),
    .job_take  (job_take)
  );

  ae32_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job       (job),
    .job_valid (job_valid),
    .job_take  (job_take),
    .oq_push   (oq_push),
    .oq_data   (oq_data),
    .oq_full   (oq_full)
  );

  ae32_rq u_rq (
    .clk    (clk),
    .rst    (rst),
    .wr     (oq_push),
    .wdata  (oq_data),
    .wfull  (oq_full),
    .rd     (pop),
    .rdata  (result),
    .rempty (empty)
  );

endmodule

>>> sim/arithmetic_encoder_32bit_test.sv
// Self-checking testbench for the 32-bit arithmetic encoder.
module arithmetic_encoder_32bit_test;
  import ae32_pkg::*;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     push = 1'b0;
  logic     pop = 1'b0;
  logic     full;
  logic     empty;
  enc_in_t  item = '0;
  enc_out_t result;

  localparam logic CMD_ENCODE = 1'b0;
  localparam logic CMD_FINISH = 1'b1;
  localparam longint unsigned FULL_RANGE = 64'hFFFF_FFFF;
  localparam longint unsigned HALF_POINT = 64'h8000_0000;
  localparam longint unsigned QUARTER_POINT = 64'h4000_0000;
  localparam longint unsigned PEND_LIMIT = 64'hFFFF_FFFF;
  localparam longint unsigned COUNT_LIMIT = (64'd1 << 48) - 1;
  localparam int CYCLE_LIMIT = 400000;

  arithmetic_encoder_32bit dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .item(item),
    .empty(empty), .pop(pop), .result(result)
  );

  always #5 clk = ~clk;

  // coder state as predicted
  longint unsigned code_low, code_high, owed_bits, emitted_bits;
  enc_out_t expected_bits[$];
  int failures = 0;
  int cycle_count = 0;
  int hold_off_cycles = 0;
  bit long_stalls = 1'b1;

  function automatic longint unsigned add_capped(longint unsigned a, longint unsigned b);
    longint unsigned s;
    s = a + b;
    return (s > COUNT_LIMIT) ? COUNT_LIMIT : s;
  endfunction

  function automatic void coder_clear();
    code_low = 0;
    code_high = FULL_RANGE;
    owed_bits = 0;
    emitted_bits = 0;
  endfunction

  function automatic void queue_bit(logic b);
    enc_out_t r;
    r = '0;
    r.has_bit = 1'b1;
    r.bit_value = b;
    r.follow_count = owed_bits[31:0];
    emitted_bits = add_capped(emitted_bits, 1 + owed_bits);
    owed_bits = 0;
    r.bits_so_far = emitted_bits[47:0];
    expected_bits.push_back(r);
  endfunction

  function automatic void predict_request(enc_in_t req);
    longint unsigned span, lo_off, hi_off, cl, ch, tot;
    bit bad;
    int emitted;
    enc_out_t r;
    cl = req.cum_low;
    ch = req.cum_high;
    tot = req.total_count;
    emitted = 0;
    r = '0;
    if (req.cmd == CMD_FINISH) begin
      if (owed_bits < PEND_LIMIT) owed_bits++;
      queue_bit(code_low < QUARTER_POINT ? 1'b0 : 1'b1);
      expected_bits[$].last = 1'b1;
      coder_clear();
      return;
    end
    span = code_high - code_low + 1;
    bad = (tot == 0) || (cl >= ch) || (ch > tot);
    if (!bad) begin
      lo_off = (span * cl) / tot;
      hi_off = (span * ch) / tot;
      if (hi_off <= lo_off) bad = 1'b1;
    end
    if (bad) begin
      r.error = 1'b1;
      r.bits_so_far = 48'(add_capped(emitted_bits, owed_bits));
      r.last = 1'b1;
      expected_bits.push_back(r);
      return;
    end
    code_high = code_low + hi_off - 1;
    code_low = code_low + lo_off;
    forever begin
      if (code_high < HALF_POINT) begin
        queue_bit(1'b0);
        emitted++;
        code_low = code_low << 1;
        code_high = (code_high << 1) | 1;
      end else if (code_low >= HALF_POINT) begin
        queue_bit(1'b1);
        emitted++;
        code_low = (code_low - HALF_POINT) << 1;
        code_high = ((code_high - HALF_POINT) << 1) | 1;
      end else if (code_low >= QUARTER_POINT && code_high < 3 * QUARTER_POINT) begin
        if (owed_bits < PEND_LIMIT) owed_bits++;
        code_low = (code_low - QUARTER_POINT) << 1;
        code_high = ((code_high - QUARTER_POINT) << 1) | 1;
      end else begin
        break;
      end
      code_low &= FULL_RANGE;
      code_high &= FULL_RANGE;
      if (emitted >= 32) break;
    end
    if (emitted == 0) begin
      r.bits_so_far = 48'(add_capped(emitted_bits, owed_bits));
      expected_bits.push_back(r);
    end else begin
      // final result also counts pending bits gathered after the last emit
      expected_bits[$].bits_so_far = 48'(add_capped(emitted_bits, owed_bits));
    end
    expected_bits[$].last = 1'b1;
  endfunction

  function automatic int gap_length();
    if ($urandom_range(0, 3) == 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    return $urandom_range(0, 3);
  endfunction

  // push stays high between back-to-back requests; drain drops it
  task automatic send_request(enc_in_t req);
    int gap;
    gap = long_stalls ? gap_length() : 0;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    item <= req;
    @(posedge clk);
    while (full) @(posedge clk);
    predict_request(req);
  endtask

  task automatic encode(int cl, int ch, int tot);
    enc_in_t req;
    req.cmd = CMD_ENCODE;
    req.cum_low = 16'(cl);
    req.cum_high = 16'(ch);
    req.total_count = 16'(tot);
    send_request(req);
  endtask

  task automatic finish_stream();
    enc_in_t req;
    req.cmd = CMD_FINISH;
    req.cum_low = 16'($urandom);
    req.cum_high = 16'($urandom);
    req.total_count = 16'($urandom);
    send_request(req);
  endtask

  task automatic drain();
    push <= 1'b0;
    while (expected_bits.size() != 0) @(posedge clk);
  endtask

  // result side: random pops, or steady pops when long stalls are off, with an optional long hold-off
  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      if (expected_bits.size() == 0) begin
        $error("result with nothing expected");
        failures++;
      end else begin
        enc_out_t e;
        e = expected_bits.pop_front();
        if (result.has_bit !== e.has_bit) begin
          $error("has_bit exp %0d got %0d", e.has_bit, result.has_bit); failures++;
        end
        if (result.bit_value !== e.bit_value) begin
          $error("bit_value exp %0d got %0d", e.bit_value, result.bit_value); failures++;
        end
        if (result.follow_count !== e.follow_count) begin
          $error("follow_count exp %0d got %0d", e.follow_count, result.follow_count);
          failures++;
        end
        if (result.bits_so_far !== e.bits_so_far) begin
          $error("bits_so_far exp %0d got %0d", e.bits_so_far, result.bits_so_far);
          failures++;
        end
        if (result.error !== e.error) begin
          $error("error exp %0d got %0d", e.error, result.error); failures++;
        end
        if (result.last !== e.last) begin
          $error("last exp %0d got %0d", e.last, result.last); failures++;
        end
      end
    end
    if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      pop <= 1'b0;
    end else if (!long_stalls) begin
      pop <= 1'b1;
    end else begin
      pop <= ($urandom_range(0, 9) < 7);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic test_directed();
    encode(0, 1, 1);
    encode(0, 1, 65535);
    encode(65534, 65535, 65535);
    encode(0, 65535, 65535);
    encode(1, 2, 3);
    encode(0, 0, 10);
    encode(5, 4, 10);
    encode(0, 11, 10);
    encode(0, 1, 0);
    encode(65535, 65535, 65535);
    encode(32767, 32768, 65535);
    encode(21845, 43690, 65535);
    encode(1, 2, 2);
    finish_stream();
    finish_stream();
    encode(32768, 32769, 65535);
    encode(16384, 49152, 65535);
    finish_stream();
    encode(16384, 49152, 65535);
    encode(0, 32767, 65535);
    encode(32768, 65535, 65535);
    finish_stream();
    drain();
  endtask

  task automatic test_random();
    int tot, cl, ch;
    repeat (70) begin
      case ($urandom_range(0, 19))
        0: finish_stream();
        1: encode($urandom_range(0, 65535), $urandom_range(0, 65535),
                  $urandom_range(0, 65535));
        default: begin
          tot = ($urandom_range(0, 1) == 1) ? $urandom_range(2, 65535)
                                            : $urandom_range(2, 16);
          cl = $urandom_range(0, tot - 1);
          ch = $urandom_range(cl + 1, tot);
          encode(cl, ch, tot);
        end
      endcase
    end
    drain();
  endtask

  task automatic test_backpressure();
    hold_off_cycles <= 3000;
    repeat (40) encode($urandom_range(0, 3), $urandom_range(4, 8), 8);
    finish_stream();
    drain();
  endtask

  task automatic test_full_rate();
    long_stalls = 1'b0;
    repeat (20) encode($urandom_range(0, 99), 100, 100);
    finish_stream();
    drain();
    long_stalls = 1'b1;
  endtask

  initial begin
    coder_clear();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random();
    test_backpressure();
    test_full_rate();
    repeat (200) @(posedge clk);
    if (failures == 0 && expected_bits.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
